>>> hdl/tsn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsn_pkg
// Shared types and constants for the triangle surface normal pipeline.
// ----------------------------------------------------------------------------
package tsn_pkg;

  localparam int SQRT_STEPS = 32;   // one root bit per cell
  localparam int DIV_STEPS  = 31;   // one quotient bit per cell
  localparam int NORM_BITS  = 31;   // scaled magnitude width

  // normalized vector riding along the root chain
  typedef struct packed {
    logic [2:0]                 neg;
    logic                       degen;
    logic [2:0][NORM_BITS-1:0]  a;
  } tsn_vec_t;

  // one slot of the square-root chain
  typedef struct packed {
    logic        vld;
    logic [63:0] num;
    logic [63:0] res;
    logic [63:0] bitv;
    tsn_vec_t    vec;
  } tsn_sqrt_t;

  // one slot of the divider chain, three lanes sharing the divisor
  typedef struct packed {
    logic                       vld;
    logic [2:0]                 neg;
    logic                       degen;
    logic [31:0]                root;
    logic [2:0][31:0]           rem;
    logic [2:0][NORM_BITS-1:0]  low;
    logic [2:0][NORM_BITS-1:0]  quo;
  } tsn_div_t;

endpackage

>>> hdl/triangle_surface_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_surface_normal
// Unit face normal of a triangle: cross product of p0-p1 and p0-p2, divided
// by its length, given in signed Q2.30.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                               | tuser
//  --------+-----------+-------------------------------------+-------------
//  in_     | slave     | p0_x p0_y p0_z p1_x .. p2_z (Q16.16)| -
//  out_    | master    | n_x n_y n_z (Q2.30, 32 bits each)   | degenerate
//
//  One triangle is taken per cycle while in_tready is high. It passes
//  9 front stages, 32 root cells, a divider setup stage, 31 divider cells
//  and the output register. The root and divider cell chains set that depth.
//  Reset (synchronous, rst_n low) clears only the valid bits of the chain.
//  A stalled output freezes the whole chain and drops in_tready together.
//
module triangle_surface_normal #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, zero fill
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // n_x, n_y, n_z
  output logic [95:0]           out_tdata,
  // degenerate
  output logic [0:0]            out_tuser
);

  localparam int NB = tsn_pkg::NORM_BITS;

  // advance everything whenever the output register is free or drained
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  tsn_pkg::tsn_sqrt_t sq_chain [tsn_pkg::SQRT_STEPS+1];
  tsn_pkg::tsn_div_t  dv_chain [tsn_pkg::DIV_STEPS+1];

  tsn_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid),
    .in_pts   (in_tdata[9*COORD_WIDTH-1:0]),
    .out_slot (sq_chain[0])
  );

  // root chain: one result bit per cell
  for (genvar g = 0; g < tsn_pkg::SQRT_STEPS; g++) begin : g_sqrt
    tsn_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .prev  (sq_chain[g]),
      .next  (sq_chain[g+1])
    );
  end

  // divider setup: numerator is a*2^30 plus half the root for rounding
  tsn_pkg::tsn_div_t  setup_r, setup_nxt;
  tsn_pkg::tsn_sqrt_t root_slot;

  assign root_slot = sq_chain[tsn_pkg::SQRT_STEPS];

  always_comb begin
    logic [61:0] numer;
    logic [31:0] root;
    root              = root_slot.res[31:0];
    setup_nxt.vld     = root_slot.vld;
    setup_nxt.neg     = root_slot.vec.neg;
    setup_nxt.degen   = root_slot.vec.degen;
    setup_nxt.root    = root;
    for (int i = 0; i < 3; i++) begin
      numer = {root_slot.vec.a[i], 31'b0} >> 1;
      numer = numer + 62'(root >> 1);
      // the top bits are already below the root, so 31 steps finish it
      setup_nxt.rem[i] = 32'(numer[61:NB]);
      setup_nxt.low[i] = numer[NB-1:0];
      setup_nxt.quo[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r.vld <= 1'b0;
    end else if (en) begin
      setup_r.vld <= setup_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      setup_r.neg   <= setup_nxt.neg;
      setup_r.degen <= setup_nxt.degen;
      setup_r.root  <= setup_nxt.root;
      setup_r.rem   <= setup_nxt.rem;
      setup_r.low   <= setup_nxt.low;
      setup_r.quo   <= setup_nxt.quo;
    end
  end

  assign dv_chain[0] = setup_r;

  for (genvar g = 0; g < tsn_pkg::DIV_STEPS; g++) begin : g_div
    tsn_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .prev  (dv_chain[g]),
      .next  (dv_chain[g+1])
    );
  end

  // output register: put signs back, zero the degenerate case
  tsn_pkg::tsn_div_t last_slot;
  logic              out_vld_r;
  logic [95:0]       out_data_r, out_data_nxt;
  logic              out_degen_r;

  assign last_slot = dv_chain[tsn_pkg::DIV_STEPS];

  always_comb begin
    logic [31:0] q;
    for (int i = 0; i < 3; i++) begin
      q = 32'(last_slot.quo[i]);
      if (last_slot.degen) begin
        out_data_nxt[i*32 +: 32] = '0;
      end else if (last_slot.neg[i]) begin
        out_data_nxt[i*32 +: 32] = -q;
      end else begin
        out_data_nxt[i*32 +: 32] = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= last_slot.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r  <= out_data_nxt;
      out_degen_r <= last_slot.degen;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_degen_r;

`ifndef SYNTHESIS
  // a degenerate triangle always reports the zero vector
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 96'd0)
    else $error("degenerate result with nonzero normal");

  // every component of a unit normal stays within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[31:0])  <= 32'sd1073741824) &&
      ($signed(out_tdata[31:0])  >= -32'sd1073741824) &&
      ($signed(out_tdata[63:32]) <= 32'sd1073741824) &&
      ($signed(out_tdata[63:32]) >= -32'sd1073741824) &&
      ($signed(out_tdata[95:64]) <= 32'sd1073741824) &&
      ($signed(out_tdata[95:64]) >= -32'sd1073741824))
    else $error("normal component out of range");

  // reset empties the chain, so nothing is offered right after it
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule

>>> hdl/tsn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsn_front
// Edges, split cross products, normalizing shift and sum of squares.
// ----------------------------------------------------------------------------
module tsn_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [9*COORD_WIDTH-1:0]  in_pts,
  output tsn_pkg::tsn_sqrt_t        out_slot
);

  localparam int E   = COORD_WIDTH + 1;
  localparam int K   = (COORD_WIDTH + 2) / 2;
  localparam int PPW = 2 * K;
  localparam int FW  = 4 * K;
  localparam int PW  = 2 * COORD_WIDTH + 2;
  localparam int CW  = 2 * COORD_WIDTH + 3;
  localparam int ML  = 2 * COORD_WIDTH + 2;
  localparam int LW  = $clog2(ML + 1);
  localparam int NB  = tsn_pkg::NORM_BITS;
  localparam int SW  = ML + NB;

  // stage A: edges
  logic signed [E-1:0] e1_r [3];
  logic signed [E-1:0] e2_r [3];
  logic signed [E-1:0] e1_nxt [3];
  logic signed [E-1:0] e2_nxt [3];
  logic                va_r;

  always_comb begin
    logic signed [E-1:0] p0, p1, p2;
    for (int i = 0; i < 3; i++) begin
      p0 = E'($signed(in_pts[i*COORD_WIDTH +: COORD_WIDTH]));
      p1 = E'($signed(in_pts[(3+i)*COORD_WIDTH +: COORD_WIDTH]));
      p2 = E'($signed(in_pts[(6+i)*COORD_WIDTH +: COORD_WIDTH]));
      e1_nxt[i] = p0 - p1;
      e2_nxt[i] = p0 - p2;
    end
  end

  // stage B: partial products of magnitudes
  logic [PPW-1:0] pp_r [6][4];
  logic [PPW-1:0] pp_nxt [6][4];
  logic [5:0]     psg_r, psg_nxt;
  logic           vb_r;

  always_comb begin
    logic signed [E-1:0] oa [6];
    logic signed [E-1:0] ob [6];
    logic [E-1:0]        ma, mb;
    logic [PPW-1:0]      xa, xb;
    oa[0] = e1_r[1]; ob[0] = e2_r[2];
    oa[1] = e1_r[2]; ob[1] = e2_r[1];
    oa[2] = e1_r[2]; ob[2] = e2_r[0];
    oa[3] = e1_r[0]; ob[3] = e2_r[2];
    oa[4] = e1_r[0]; ob[4] = e2_r[1];
    oa[5] = e1_r[1]; ob[5] = e2_r[0];
    for (int k = 0; k < 6; k++) begin
      ma = oa[k][E-1] ? E'(-oa[k]) : E'(oa[k]);
      mb = ob[k][E-1] ? E'(-ob[k]) : E'(ob[k]);
      xa = PPW'(ma);
      xb = PPW'(mb);
      psg_nxt[k]   = oa[k][E-1] ^ ob[k][E-1];
      pp_nxt[k][0] = PPW'(xa[K-1:0]) * PPW'(xb[K-1:0]);
      pp_nxt[k][1] = PPW'(xa[K-1:0]) * PPW'(xb[PPW-1:K]);
      pp_nxt[k][2] = PPW'(xa[PPW-1:K]) * PPW'(xb[K-1:0]);
      pp_nxt[k][3] = PPW'(xa[PPW-1:K]) * PPW'(xb[PPW-1:K]);
    end
  end

  // stage C: signed products
  logic signed [PW-1:0] prod_r [6];
  logic signed [PW-1:0] prod_nxt [6];
  logic                 vc_r;

  always_comb begin
    logic [FW-1:0] full;
    logic [PW-1:0] m;
    for (int k = 0; k < 6; k++) begin
      full = (FW'(pp_r[k][3]) << PPW)
           + ((FW'(pp_r[k][1]) + FW'(pp_r[k][2])) << K)
           + FW'(pp_r[k][0]);
      m = full[PW-1:0];
      prod_nxt[k] = psg_r[k] ? $signed(-m) : $signed(m);
    end
  end

  // stage D: cross components
  logic signed [CW-1:0] c_r [3];
  logic signed [CW-1:0] c_nxt [3];
  logic                 vd_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_nxt[i] = CW'(prod_r[2*i]) - CW'(prod_r[2*i+1]);
    end
  end

  // stage E: sign and magnitude
  logic [ML-1:0] mag_r [3];
  logic [ML-1:0] mag_nxt [3];
  logic [2:0]    neg_e_r, neg_e_nxt;
  logic          ve_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_e_nxt[i] = c_r[i][CW-1];
      mag_nxt[i]   = c_r[i][CW-1] ? ML'(-c_r[i]) : ML'(c_r[i]);
    end
  end

  // stage F: bit length of the largest magnitude
  logic [ML-1:0] mag_f_r [3];
  logic [2:0]    neg_f_r;
  logic [LW-1:0] len_r, len_nxt;
  logic          vf_r;

  always_comb begin
    logic [ML-1:0] orv;
    orv = mag_r[0] | mag_r[1] | mag_r[2];
    len_nxt = '0;
    for (int b = 0; b < ML; b++) begin
      if (orv[b]) begin
        len_nxt = LW'(b + 1);
      end
    end
  end

  // stage G: common shift to NORM_BITS
  logic [NB-1:0] a_r [3];
  logic [NB-1:0] a_nxt [3];
  logic [2:0]    neg_g_r;
  logic          degen_g_r;
  logic          vg_r;

  always_comb begin
    logic [SW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh = {mag_f_r[i], {NB{1'b0}}} >> len_r;
      a_nxt[i] = sh[NB-1:0];
    end
  end

  // stage H: squares
  logic [2*NB-1:0] sq_r [3];
  logic [NB-1:0]   a_h_r [3];
  logic [2:0]      neg_h_r;
  logic            degen_h_r;
  logic            vh_r;

  // stage I: sum of squares, launch into the root chain
  tsn_pkg::tsn_sqrt_t slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      vh_r <= 1'b0;
      slot_r.vld <= 1'b0;
    end else if (en) begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
      vg_r <= vf_r;
      vh_r <= vg_r;
      slot_r.vld <= vh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r      <= e1_nxt;
      e2_r      <= e2_nxt;
      pp_r      <= pp_nxt;
      psg_r     <= psg_nxt;
      prod_r    <= prod_nxt;
      c_r       <= c_nxt;
      mag_r     <= mag_nxt;
      neg_e_r   <= neg_e_nxt;
      mag_f_r   <= mag_r;
      neg_f_r   <= neg_e_r;
      len_r     <= len_nxt;
      a_r       <= a_nxt;
      neg_g_r   <= neg_f_r;
      degen_g_r <= (len_r == '0);
      for (int i = 0; i < 3; i++) begin
        sq_r[i]  <= (2*NB)'(a_r[i]) * (2*NB)'(a_r[i]);
        a_h_r[i] <= a_r[i];
        slot_r.vec.a[i] <= a_h_r[i];
      end
      neg_h_r   <= neg_g_r;
      degen_h_r <= degen_g_r;
      slot_r.num  <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
      slot_r.res  <= '0;
      slot_r.bitv <= 64'h4000_0000_0000_0000;
      slot_r.vec.neg   <= neg_h_r;
      slot_r.vec.degen <= degen_h_r;
    end
  end

  assign out_slot = slot_r;

endmodule

>>> hdl/tsn_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsn_sqrt_cell
// One digit step of the integer square root; the trial bit travels along.
// ----------------------------------------------------------------------------
module tsn_sqrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  tsn_pkg::tsn_sqrt_t prev,
  output tsn_pkg::tsn_sqrt_t next
);

  tsn_pkg::tsn_sqrt_t slot_r, slot_nxt;

  always_comb begin
    logic [63:0] trial;
    trial    = prev.res + prev.bitv;
    slot_nxt = prev;
    if (prev.num >= trial) begin
      slot_nxt.num = prev.num - trial;
      slot_nxt.res = (prev.res >> 1) + prev.bitv;
    end else begin
      slot_nxt.res = prev.res >> 1;
    end
    slot_nxt.bitv = prev.bitv >> 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else if (en) begin
      slot_r.vld <= prev.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot_r.num  <= slot_nxt.num;
      slot_r.res  <= slot_nxt.res;
      slot_r.bitv <= slot_nxt.bitv;
      slot_r.vec  <= slot_nxt.vec;
    end
  end

  assign next = slot_r;

endmodule

>>> hdl/tsn_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsn_div_cell
// One restoring division step for three lanes sharing one divisor.
// ----------------------------------------------------------------------------
module tsn_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tsn_pkg::tsn_div_t prev,
  output tsn_pkg::tsn_div_t next
);

  localparam int NB = tsn_pkg::NORM_BITS;

  tsn_pkg::tsn_div_t slot_r, slot_nxt;

  always_comb begin
    logic [32:0] t;
    slot_nxt = prev;
    for (int i = 0; i < 3; i++) begin
      t = {prev.rem[i], prev.low[i][NB-1]};
      if (t >= {1'b0, prev.root}) begin
        slot_nxt.rem[i] = 32'(t - {1'b0, prev.root});
        slot_nxt.quo[i] = {prev.quo[i][NB-2:0], 1'b1};
      end else begin
        slot_nxt.rem[i] = t[31:0];
        slot_nxt.quo[i] = {prev.quo[i][NB-2:0], 1'b0};
      end
      slot_nxt.low[i] = {prev.low[i][NB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
    end else if (en) begin
      slot_r.vld <= prev.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot_r.neg   <= slot_nxt.neg;
      slot_r.degen <= slot_nxt.degen;
      slot_r.root  <= slot_nxt.root;
      slot_r.rem   <= slot_nxt.rem;
      slot_r.low   <= slot_nxt.low;
      slot_r.quo   <= slot_nxt.quo;
    end
  end

  assign next = slot_r;

endmodule
